### sv/modexp_pkg.sv
package modexp_pkg;

  localparam int unsigned WIDTH  = 64;
  localparam int unsigned DATA_W = WIDTH;
  localparam int unsigned MOD_W  = WIDTH - 1;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [MOD_W-1:0]  mod_t;

  typedef struct packed {
    logic start;
    logic reduce;
  } mul_ctrl_t;

endpackage

### sv/modexp_if.sv
interface modexp_in_if;
  logic                 valid;
  logic                 ready;
  modexp_pkg::data_t    base;
  modexp_pkg::data_t    exponent;
  modexp_pkg::mod_t     modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface modexp_out_if;
  logic                 valid;
  logic                 ready;
  modexp_pkg::data_t    power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

### sv/modexp_mul.sv
module modexp_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  modexp_pkg::mul_ctrl_t ctrl_i,
  input  modexp_pkg::data_t     x_i,
  input  modexp_pkg::data_t     y_i,
  input  modexp_pkg::mod_t      m_i,
  output logic                  done_o,
  output modexp_pkg::data_t     prod_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              reduce_q, reduce_d;
  modexp_pkg::data_t x_q, x_d;
  modexp_pkg::data_t y_q, y_d;
  modexp_pkg::data_t acc_q, acc_d;
  modexp_pkg::data_t m_ext;
  modexp_pkg::data_t acc_sum;
  modexp_pkg::data_t y_dbl;

  assign m_ext   = {1'b0, m_i};
  assign acc_sum = acc_q + y_q;
  assign y_dbl   = {y_q[modexp_pkg::DATA_W-2:0], 1'b0};

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    reduce_d = reduce_q;
    x_d      = x_q;
    y_d      = y_q;
    acc_d    = acc_q;
    if (ctrl_i.start) begin
      busy_d   = 1'b1;
      reduce_d = ctrl_i.reduce;
      x_d      = x_i;
      y_d      = y_i;
      acc_d    = '0;
    end else if (busy_q) begin
      if (x_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (x_q[0]) begin
          acc_d = (reduce_q && acc_sum >= m_ext) ? acc_sum - m_ext : acc_sum;
        end
        y_d = (reduce_q && y_dbl >= m_ext) ? y_dbl - m_ext : y_dbl;
        x_d = x_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reduce_q <= reduce_d;
    x_q      <= x_d;
    y_q      <= y_d;
    acc_q    <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### sv/modular_exponentiation.sv
// Modular exponentiation, base ** exponent mod modulus, 64-bit operands.
// Input channel in_i carries base, exponent and a 63-bit modulus; a
// transaction happens when valid and ready are high at a rising edge.
// Output channel out_o carries power_result, one transaction per input.
// A modulus of zero gives the power wrapped to 64 bits.
// Right-to-left square and multiply on one shared shift-add multiplier:
// each modular product adds and doubles over the significant bits of its
// first operand, lowest first, and stops when no set bit remains.
// An item takes one base reduction when the modulus is nonzero, then one
// square per exponent bit below the top set bit and one multiply per set
// bit: at most 127 products plus the reduction, far fewer for short
// exponents. in_i.ready is high only while no item is being worked on.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver still stalls when the next result is done, the
// block holds that result and stays busy until the register frees.
// Reset (rst_ni low, asynchronous) drops any item in flight and clears
// out_o.valid; the block comes out of reset idle and ready.
module modular_exponentiation (
  input  logic               clk_i,
  input  logic               rst_ni,
  modexp_in_if.sink          in_i,
  modexp_out_if.source       out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_BIT,
    S_MUL,
    S_SQR,
    S_OUT
  } state_e;

  state_e                state_q, state_d;
  logic                  issued_q, issued_d;
  logic                  out_valid_q, out_valid_d;
  modexp_pkg::data_t     out_data_q, out_data_d;
  modexp_pkg::data_t     e_q, e_d;
  modexp_pkg::data_t     b_q, b_d;
  modexp_pkg::data_t     acc_q, acc_d;
  modexp_pkg::mod_t      m_q, m_d;
  modexp_pkg::data_t     one_q, one_d;

  modexp_pkg::mul_ctrl_t mul_ctrl;
  modexp_pkg::data_t     mul_x;
  modexp_pkg::data_t     mul_y;
  logic                  mul_done;
  modexp_pkg::data_t     mul_prod;
  logic                  out_free;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    mul_x = b_q;
    mul_y = b_q;
    case (state_q)
      S_RED: begin
        mul_x = b_q;
        mul_y = one_q;
      end
      S_MUL: begin
        mul_x = acc_q;
        mul_y = b_q;
      end
      default: begin
        mul_x = b_q;
        mul_y = b_q;
      end
    endcase
  end

  always_comb begin
    state_d         = state_q;
    issued_d        = issued_q;
    out_valid_d     = out_valid_q;
    out_data_d      = out_data_q;
    e_d             = e_q;
    b_d             = b_q;
    acc_d           = acc_q;
    m_d             = m_q;
    one_d           = one_q;
    mul_ctrl.start  = 1'b0;
    mul_ctrl.reduce = (m_q != '0);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          e_d   = in_i.exponent;
          b_d   = in_i.base;
          m_d   = in_i.modulus;
          one_d = (in_i.modulus == modexp_pkg::mod_t'(1)) ? '0 : modexp_pkg::data_t'(1);
          acc_d = one_d;
          state_d = (in_i.modulus == '0) ? S_BIT : S_RED;
        end
      end
      S_RED, S_MUL, S_SQR: begin
        if (!issued_q) begin
          mul_ctrl.start = 1'b1;
          issued_d       = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          case (state_q)
            S_RED: begin
              b_d     = mul_prod;
              state_d = S_BIT;
            end
            S_MUL: begin
              acc_d   = mul_prod;
              state_d = (e_q[modexp_pkg::DATA_W-1:1] == '0) ? S_OUT : S_SQR;
            end
            default: begin
              b_d     = mul_prod;
              e_d     = e_q >> 1;
              state_d = S_BIT;
            end
          endcase
        end
      end
      S_BIT: begin
        if (e_q == '0) begin
          state_d = S_OUT;
        end else if (e_q[0]) begin
          state_d = S_MUL;
        end else begin
          state_d = S_SQR;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    e_q        <= e_d;
    b_q        <= b_d;
    acc_q      <= acc_d;
    m_q        <= m_d;
    one_q      <= one_d;
  end

  modexp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .m_i    (m_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.power_result = out_data_q;

endmodule

### test/tb_modular_exponentiation.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 20_000;
  localparam int unsigned RANDOM_ITEMS = 81;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    modexp_pkg::data_t base;
    modexp_pkg::data_t exponent;
    modexp_pkg::mod_t  modulus;
  } modexp_item_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  modexp_in_if  in_if ();
  modexp_out_if out_if ();

  modular_exponentiation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  modexp_item_t      pending_q[$];
  modexp_pkg::data_t expected_power_q[$];
  int unsigned       error_cnt    = 0;
  int unsigned       results_seen = 0;
  int unsigned       cycle_cnt    = 0;
  logic              hold_off     = 1'b0;

  // x * y mod m by shift-add with a subtract after every add; m == 0 wraps
  function automatic modexp_pkg::data_t mul_reduce(modexp_pkg::data_t x,
                                                   modexp_pkg::data_t y,
                                                   modexp_pkg::mod_t m);
    modexp_pkg::data_t acc;
    modexp_pkg::data_t addend;
    modexp_pkg::data_t mm;
    if (m == '0) begin
      return x * y;
    end
    mm     = {1'b0, m};
    acc    = '0;
    addend = y;
    for (int i = 0; i < modexp_pkg::DATA_W; i++) begin
      if (x[i]) begin
        acc = acc + addend;
        if (acc >= mm) acc = acc - mm;
      end
      addend = addend + addend;
      if (addend >= mm) addend = addend - mm;
    end
    return acc;
  endfunction

  // right-to-left square and multiply
  function automatic modexp_pkg::data_t mod_pow(modexp_pkg::data_t b,
                                                modexp_pkg::data_t e,
                                                modexp_pkg::mod_t m);
    modexp_pkg::data_t pw;
    modexp_pkg::data_t acc;
    modexp_pkg::data_t mm;
    mm = {1'b0, m};
    if (m != '0) begin
      pw  = b % mm;
      acc = modexp_pkg::data_t'(1) % mm;
    end else begin
      pw  = b;
      acc = modexp_pkg::data_t'(1);
    end
    for (int i = 0; i < modexp_pkg::DATA_W; i++) begin
      if (e[i]) acc = mul_reduce(acc, pw, m);
      pw = mul_reduce(pw, pw, m);
    end
    return acc;
  endfunction

  task automatic add_item(modexp_pkg::data_t b, modexp_pkg::data_t e, modexp_pkg::mod_t m);
    modexp_item_t item;
    item.base     = b;
    item.exponent = e;
    item.modulus  = m;
    pending_q = {pending_q, item};
  endtask

  // driver: bursts of transactions separated by random gaps
  int unsigned gap_left;
  int unsigned burst_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.base     <= '0;
      in_if.exponent <= '0;
      in_if.modulus  <= '0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_power_q = {expected_power_q,
                            mod_pow(in_if.base, in_if.exponent, in_if.modulus)};
        void'(pending_q.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid    <= 1'b1;
          in_if.base     <= pending_q[0].base;
          in_if.exponent <= pending_q[0].exponent;
          in_if.modulus  <= pending_q[0].modulus;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: gap_left = 0;
              6, 7, 8:          gap_left = $urandom_range(1, 20);
              default:          gap_left = $urandom_range(50, 600);
            endcase
          end
        end
      end
    end
  end

  // monitor: checks results, stalls on a mode pattern
  rx_mode_e          rx_mode;
  int unsigned       mode_left;
  logic              ready_next;
  modexp_pkg::data_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_power_q.size() == 0) begin
          $error("power_result: transaction with nothing expected, actual %h",
                 out_if.power_result);
          error_cnt++;
        end else begin
          want = expected_power_q.pop_front();
          if (out_if.power_result !== want) begin
            $error("power_result mismatch: expected %h, actual %h",
                   want, out_if.power_result);
            error_cnt++;
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 256);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   ready_next = 1'b1;
        RX_RANDOM: ready_next = 1'($urandom_range(0, 1));
        default:   ready_next = ($urandom_range(0, 7) == 0);
      endcase
      out_if.ready <= ready_next && !hold_off;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (results_seen >= 22);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    modexp_pkg::data_t b;
    modexp_pkg::data_t e;
    modexp_pkg::data_t m_raw;
    int unsigned       w;

    rst_ni = 1'b0;

    // directed
    add_item('0, '0, '0);
    add_item('0, '0, modexp_pkg::mod_t'(1));
    add_item('1, '0, modexp_pkg::mod_t'(5));
    add_item('1, '1, '0);
    add_item('1, '1, '1);
    add_item(64'h8000_0000_0000_0000, 64'd1, modexp_pkg::mod_t'(7));
    add_item(64'd3, 64'd1, '0);
    add_item(64'd5, 64'h8000_0000_0000_0000, '1);
    add_item('0, 64'd5, modexp_pkg::mod_t'(13));
    add_item({$urandom, $urandom}, {$urandom, $urandom}, modexp_pkg::mod_t'(1));
    add_item(64'd1, '1, '0);
    add_item(64'd2, 64'd64, '0);
    add_item(64'd2, 64'd63, '0);
    add_item(64'd12345, 64'd65537, modexp_pkg::mod_t'(64'h1FFF_FFFF_FFFF_FFFF));
    add_item('1, 64'd2, modexp_pkg::mod_t'(2));
    add_item('1, 64'd3, modexp_pkg::mod_t'(64'h4000_0000_0000_0000));
    add_item(64'd7, 64'd10, modexp_pkg::mod_t'(1000));
    add_item(64'd1000003, 64'd3, modexp_pkg::mod_t'(1000003));
    add_item(64'h7FFF_FFFF_FFFF_FFFE, 64'd2, '1);

    // random, short exponents mostly
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 5))
        0:       b = modexp_pkg::data_t'($urandom_range(0, 3));
        1:       b = '1;
        default: b = {$urandom, $urandom};
      endcase
      e = {$urandom, $urandom};
      if ($urandom_range(0, 9) != 0) begin
        w = $urandom_range(0, 16);
        e = e & ((64'd1 << w) - 64'd1);
      end
      case ($urandom_range(0, 15))
        0, 1:    m_raw = '0;
        2:       m_raw = 64'd1;
        3, 4, 5: m_raw = {$urandom, $urandom};
        default: begin
          w     = $urandom_range(1, modexp_pkg::MOD_W);
          m_raw = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
        end
      endcase
      add_item(b, e, m_raw[modexp_pkg::MOD_W-1:0]);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0) @(posedge clk_i);
    while (expected_power_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0 && expected_power_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
